FILE: rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-256 core: controller states,
// controller-to-datapath command and status groups, hash constants.
// ----------------------------------------------------------------------------
package sha_pkg;

	// Controller states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOAD   = 6'b000010,
		ST_ROUND  = 6'b000100,
		ST_UPDATE = 6'b001000,
		ST_PAD    = 6'b010000,
		ST_LEN    = 6'b100000
	} state_t;

	// Kind of block being compressed
	typedef enum logic [1:0] {
		BLK_DATA    = 2'b00,
		BLK_PADFULL = 2'b01,
		BLK_FINAL   = 2'b10
	} blk_kind_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       byte_wr;   // store the accepted message byte
		logic       pad_wr;    // store 0x80 and clear the rest of the block
		logic       len_wr;    // store the bit length in the last two words
		logic       clr_all;   // with len_wr: clear words ahead of the length
		logic       load;      // copy hash state into working variables
		logic       round;     // run one compression round
		logic [5:0] rnd;       // round number
		logic       update;    // fold working variables into hash state
		logic       fin;       // with update: emit digest, restart hash
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic fill_full;       // next byte completes the block
		logic fill_late;       // no room for the length after the pad byte
		logic out_busy;        // digest words still waiting to be taken
	} sts_t;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam int         BLK_WORDS  = 16;
	localparam logic [5:0] LAST_FILL  = 6'd63;
	localparam logic [5:0] LATE_FILL  = 6'd55;
	localparam logic [5:0] LAST_ROUND = 6'd63;

	localparam logic [31:0] H_INIT [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_ROM [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

FILE: rtl/core/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer of the SHA-256 core: takes input items, runs the round counter,
// steps through padding, length insertion and the final compression.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          has_byte,
	input  logic          is_last,
	input  sha_pkg::sts_t sts,
	output sha_pkg::cmd_t cmd
);

	sha_pkg::state_t    state_q, state_d;
	sha_pkg::blk_kind_t kind_q, kind_d;
	logic [5:0]         rnd_q, rnd_d;
	logic               pend_q, pend_d;
	logic               accept;

	assign in_ready = (state_q == sha_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		rnd_d   = rnd_q;
		pend_d  = pend_q;
		cmd     = '0;
		cmd.rnd = rnd_q;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.byte_wr = has_byte;
					if (has_byte && sts.fill_full) begin
						pend_d  = is_last;
						kind_d  = sha_pkg::BLK_DATA;
						state_d = sha_pkg::ST_LOAD;
					end else if (is_last) begin
						state_d = sha_pkg::ST_PAD;
					end
				end
			end
			sha_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				rnd_d    = '0;
				state_d  = sha_pkg::ST_ROUND;
			end
			sha_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == sha_pkg::LAST_ROUND) begin
					state_d = sha_pkg::ST_UPDATE;
				end
			end
			sha_pkg::ST_UPDATE: begin
				case (kind_q)
					sha_pkg::BLK_FINAL: begin
						// hold until the previous digest has drained
						if (!sts.out_busy) begin
							cmd.update = 1'b1;
							cmd.fin    = 1'b1;
							state_d    = sha_pkg::ST_IDLE;
						end
					end
					sha_pkg::BLK_PADFULL: begin
						cmd.update = 1'b1;
						state_d    = sha_pkg::ST_LEN;
					end
					default: begin
						cmd.update = 1'b1;
						state_d    = pend_q ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
					end
				endcase
			end
			sha_pkg::ST_PAD: begin
				cmd.pad_wr = 1'b1;
				if (sts.fill_late) begin
					kind_d  = sha_pkg::BLK_PADFULL;
					state_d = sha_pkg::ST_LOAD;
				end else begin
					kind_d  = sha_pkg::BLK_DATA;
					state_d = sha_pkg::ST_LEN;
				end
			end
			sha_pkg::ST_LEN: begin
				cmd.len_wr  = 1'b1;
				cmd.clr_all = (kind_q == sha_pkg::BLK_PADFULL);
				kind_d      = sha_pkg::BLK_FINAL;
				state_d     = sha_pkg::ST_LOAD;
			end
			default: begin
				state_d = sha_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			kind_q  <= sha_pkg::BLK_DATA;
			rnd_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			rnd_q   <= rnd_d;
			pend_q  <= pend_d;
		end
	end

	// Checks
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ROUND && rnd_q == sha_pkg::LAST_ROUND)
		|=> (state_q == sha_pkg::ST_UPDATE))
		else $error("round 63 not followed by update");

	a_last_pads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_last && !(has_byte && sts.fill_full))
		|=> (state_q == sha_pkg::ST_PAD))
		else $error("end item did not start padding");

	a_final_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_LEN)
		|=> (state_q == sha_pkg::ST_LOAD && kind_q == sha_pkg::BLK_FINAL))
		else $error("length insert not followed by final block");

endmodule

FILE: rtl/core/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Datapath of the SHA-256 core: 16-word block buffer that doubles as the
// message schedule window, round unit, hash state, length counter and the
// digest output register.
// ----------------------------------------------------------------------------
module sha_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  sha_pkg::cmd_t cmd,
	output sha_pkg::sts_t sts,
	input  logic [7:0]    msg_byte,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          last_word
);

	logic [31:0] w_q   [sha_pkg::BLK_WORDS];
	logic [31:0] h_q   [8];
	logic [31:0] v_q   [8];
	logic [31:0] dig_q [8];
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic        out_valid_q;
	logic [2:0]  out_idx_q;

	logic [63:0] bit_len;
	logic [7:0]  wr_byte;
	logic [31:0] t1, t2, sched;
	logic        out_take;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// Place a byte in its lane (lane 0 is the top byte) and clear later lanes
	function automatic logic [31:0] put_byte(input logic [31:0] word,
		input logic [1:0] lane, input logic [7:0] b);
		logic [31:0] r;
		r = word;
		case (lane)
			2'd0:    r = {b, 24'd0};
			2'd1:    r = {word[31:24], b, 16'd0};
			2'd2:    r = {word[31:16], b, 8'd0};
			default: r = {word[31:8], b};
		endcase
		return r;
	endfunction

	assign bit_len = {total_q, 3'b000};
	assign wr_byte = cmd.pad_wr ? sha_pkg::PAD_BYTE : msg_byte;

	// Round function
	always_comb begin
		t1 = v_q[7]
			+ (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::K_ROM[cmd.rnd]
			+ w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Next schedule word, entering at the top of the window
	assign sched = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10))
		+ w_q[9]
		+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
		+ w_q[0];

	// Block buffer / schedule window
	always_ff @(posedge clk) begin
		if (cmd.byte_wr || cmd.pad_wr) begin
			for (int i = 0; i < sha_pkg::BLK_WORDS; i++) begin
				if (4'(i) == fill_q[5:2]) begin
					w_q[i] <= put_byte(w_q[i], fill_q[1:0], wr_byte);
				end else if (cmd.pad_wr && 4'(i) > fill_q[5:2]) begin
					w_q[i] <= '0;
				end
			end
		end else if (cmd.len_wr) begin
			for (int i = 0; i < sha_pkg::BLK_WORDS - 2; i++) begin
				if (cmd.clr_all) begin
					w_q[i] <= '0;
				end
			end
			w_q[sha_pkg::BLK_WORDS - 2] <= bit_len[63:32];
			w_q[sha_pkg::BLK_WORDS - 1] <= bit_len[31:0];
		end else if (cmd.round) begin
			for (int i = 0; i < sha_pkg::BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[sha_pkg::BLK_WORDS - 1] <= sched;
		end
	end

	// Working variables a..h
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// Hash state, fill and length counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::H_INIT[i];
			end
			fill_q  <= '0;
			total_q <= '0;
		end else begin
			if (cmd.update) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= cmd.fin ? sha_pkg::H_INIT[i] : h_q[i] + v_q[i];
				end
			end
			if (cmd.update && cmd.fin) begin
				fill_q  <= '0;
				total_q <= '0;
			end else if (cmd.byte_wr) begin
				fill_q  <= fill_q + 6'd1;
				total_q <= total_q + 61'd1;
			end
		end
	end

	// Digest output register, shifted out one word per item
	assign out_take = out_valid_q && out_ready;

	always_ff @(posedge clk) begin
		if (cmd.update && cmd.fin) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[i] <= h_q[i] + v_q[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < 7; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else if (cmd.update && cmd.fin) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= '0;
		end else if (out_take) begin
			out_idx_q <= out_idx_q + 3'd1;
			if (out_idx_q == 3'd7) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = dig_q[0];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'd7);

	assign sts.fill_full = (fill_q == sha_pkg::LAST_FILL);
	assign sts.fill_late = (fill_q > sha_pkg::LATE_FILL);
	assign sts.out_busy  = out_valid_q;

	// Checks
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && cmd.fin) |-> !out_valid_q)
		else $error("digest overwritten while words pending");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && cmd.fin) |=> (fill_q == '0 && total_q == '0))
		else $error("counters not cleared after digest");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> ($past(out_idx_q) == 3'd7))
		else $error("digest output ended before word 7");

endmodule

FILE: rtl/core/sha256_hash.sv
// ----------------------------------------------------------------------------
// sha256_hash
// Streaming SHA-256 core, top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per handshake: msg_byte
//   qualified by has_byte, and is_last to close the message. An end item may
//   carry no byte, so an empty message is one bare end item.
//   Output channel (out_valid/out_ready) gives the digest as eight items,
//   H0 first, each with its word_index; last_word marks the eighth.
// Sequencing:
//   A byte that does not complete a 64-byte block is taken while the core
//   stays idle. A byte that completes one starts a block: load, 64 rounds,
//   state update, run on the single shared round unit; no new item is taken
//   until it ends. An end item adds a pad step, a length step and one block,
//   or two blocks when fewer than 8 bytes remain after the pad.
// Stalls and reset:
//   The digest sits in its own output register; a new message is taken while
//   it drains. Only the next final block waits until the old digest is gone.
//   Reset loads the initial hash and clears the byte and length counters.
// ----------------------------------------------------------------------------
module sha256_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_pkg::cmd_t cmd;
	sha_pkg::sts_t sts;

	// Sequencer
	sha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.has_byte (has_byte),
		.is_last  (is_last),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	sha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.msg_byte    (msg_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
